// ===== hdl/assert_macros.svh =====
// Assertion shorthands, sampled on clk and held off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tdbe check failed");

`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tdbe check failed");

`endif

// ===== hdl/tdbe_pkg.sv =====
`default_nettype none
package tdbe_pkg;

	localparam int SINE_TABLE_DEPTH = 256;
	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);

	localparam int FULL_TURN = 46080;
	localparam int QUARTER_TURN = 11520;
	localparam int HALF_QUARTER = 5760;
	// quarter turn is 256 * 45: shift by 8, then multiply by a reciprocal of 45
	localparam int SCALED_W = $clog2(QUARTER_TURN * SINE_TABLE_DEPTH + HALF_QUARTER);
	localparam int SHIFTED_W = SCALED_W - 8;
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W = 19;
	localparam int RECIP_45 = ((1 << RECIP_SHIFT) + 44) / 45;

	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam longint I48_MAX = 64'sd140737488355327;
	localparam longint I48_MIN = -64'sd140737488355328;

	localparam logic REG_BRAKE_ANGLE = 1'b0;
	localparam logic REG_DRAG_COEF = 1'b1;

	typedef logic [15:0] sine_tab_t [SINE_TABLE_DEPTH];

	typedef enum logic [3:0] {
		S_IDLE, S_ANG, S_EARTH, S_LEAK, S_DIFF, S_DELTA, S_UPD, S_BODY, S_POST, S_DIV, S_DONE
	} state_t;

	// term * x^2 in Q30
	function automatic longint sq_step(input longint term, input longint x);
		longint t;
		t = (term * x) / ONE_Q30;
		return (t * x) / ONE_Q30;
	endfunction

	function automatic sine_tab_t build_sine_table();
		sine_tab_t t;
		longint x, term, sum, v;
		int i;
		for (i = 0; i < SINE_TABLE_DEPTH; i++) begin
			x = longint'(i) * HALF_PI_Q30 / SINE_TABLE_DEPTH;
			term = x;
			sum = x;
			term = -sq_step(term, x) / 64'sd6;
			sum += term;
			term = -sq_step(term, x) / 64'sd20;
			sum += term;
			term = -sq_step(term, x) / 64'sd42;
			sum += term;
			term = -sq_step(term, x) / 64'sd72;
			sum += term;
			term = -sq_step(term, x) / 64'sd110;
			sum += term;
			v = (sum + 64'sd16384) / 64'sd32768;
			if (v < 0)
				v = 0;
			if (v > 32768)
				v = 32768;
			t[i] = v[15:0];
		end
		return t;
	endfunction

	localparam sine_tab_t SINE_TABLE = build_sine_table();

	// 48 bit value split into a signed upper and an unsigned lower half for the MAC
	function automatic logic signed [24:0] lo25(input logic [47:0] v);
		return $signed({1'b0, v[23:0]});
	endfunction

	function automatic logic signed [24:0] hi25(input logic [47:0] v);
		return $signed({v[47], v[47:24]});
	endfunction

endpackage
`default_nettype wire

// ===== hdl/tilt_drag_brake_estimator_unit.sv =====
// channel   dir  handshake          payload
// s         in   s_tvalid/s_tready  s_tdata 96b, s_tuser 1b (mode)
// m         out  m_tvalid/m_tready  m_tdata 160b
// cfg       in   cfg_we             cfg_index 1b, cfg_data 16b
//
// The work on each word is done by the shared
// 17x25 MAC (20 steps) and the bit-serial divider (32 steps per axis).
// s_tready is high only while idle; the result sits in an output register
// and the next word is taken while it waits. m_tready low holds the result.
// arst_n clears control and integrators and loads the config defaults; no clearing pass.
`default_nettype none
module tilt_drag_brake_estimator_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	// roll_angle, pitch_angle, yaw_angle, roll_trim, pitch_trim, time_step
	input  wire logic [95:0]   s_tdata,
	// mode
	input  wire logic          s_tuser,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	// body_integral_x, body_integral_y, brake_time_x, brake_time_y, brake_roll, brake_pitch
	output logic [159:0]       m_tdata,
	input  wire logic          cfg_we,
	input  wire logic          cfg_index,
	input  wire logic [15:0]   cfg_data
);

	tdbe_pkg::state_t state_q, state_d;
	logic [4:0] cnt_q;
	logic j_q;

	logic [14:0] ba_q;
	logic [15:0] drag_q;

	logic mode_q;
	logic signed [15:0] yaw_q;
	logic signed [15:0] trim_q [2];
	logic signed [16:0] tilt_q [2];
	logic [15:0] dt_q;

	logic signed [16:0] sin_q, cos_q;
	logic [tdbe_pkg::IDX_W-1:0] idx_q;
	logic [1:0] quad_q;

	logic signed [65:0] acc_q, acc_d;
	logic signed [34:0] e_q [2];
	logic signed [47:0] integ_q [2];
	logic signed [47:0] diff_q;
	logic signed [50:0] body_q [2];

	logic [14:0] rem_q;
	logic [31:0] quo_q;

	logic signed [31:0] res_bi_q [2];
	logic [31:0] res_bt_q [2];
	logic signed [15:0] res_cmd_q [2];

	logic m_tvalid_q;
	logic [159:0] m_tdata_q;

	// angle unit
	logic ang_cos;
	logic signed [17:0] ang_p;
	logic [15:0] ang_m;
	logic [1:0] ang_quad;
	logic [13:0] ang_r;
	logic [tdbe_pkg::SCALED_W-1:0] ang_n;
	logic [tdbe_pkg::SHIFTED_W+tdbe_pkg::RECIP_W-1:0] ang_prod;
	logic [tdbe_pkg::IDX_W-1:0] ang_idx;
	logic [tdbe_pkg::IDX_W-1:0] tab_k;
	logic signed [16:0] tab_mag, tab_val;

	always_comb begin
		ang_p = 18'(yaw_q) + (ang_cos ? 18'sd11520 : 18'sd0);
		ang_m = ang_p[17] ? 16'(ang_p + 18'sd46080) : ang_p[15:0];
		if (ang_m >= 16'(3 * tdbe_pkg::QUARTER_TURN)) begin
			ang_quad = 2'd3;
			ang_r = 14'(ang_m - 16'(3 * tdbe_pkg::QUARTER_TURN));
		end else if (ang_m >= 16'(2 * tdbe_pkg::QUARTER_TURN)) begin
			ang_quad = 2'd2;
			ang_r = 14'(ang_m - 16'(2 * tdbe_pkg::QUARTER_TURN));
		end else if (ang_m >= 16'(tdbe_pkg::QUARTER_TURN)) begin
			ang_quad = 2'd1;
			ang_r = 14'(ang_m - 16'(tdbe_pkg::QUARTER_TURN));
		end else begin
			ang_quad = 2'd0;
			ang_r = ang_m[13:0];
		end
		ang_n = tdbe_pkg::SCALED_W'(ang_r) * tdbe_pkg::SCALED_W'(tdbe_pkg::SINE_TABLE_DEPTH)
			+ tdbe_pkg::SCALED_W'(tdbe_pkg::HALF_QUARTER);
		ang_prod = (tdbe_pkg::SHIFTED_W+tdbe_pkg::RECIP_W)'(ang_n[tdbe_pkg::SCALED_W-1:8])
			* (tdbe_pkg::SHIFTED_W+tdbe_pkg::RECIP_W)'(tdbe_pkg::RECIP_45);
		ang_idx = tdbe_pkg::IDX_W'(ang_prod >> tdbe_pkg::RECIP_SHIFT);

		tab_k = quad_q[0] ? tdbe_pkg::IDX_W'(tdbe_pkg::SINE_TABLE_DEPTH) - idx_q : idx_q;
		if (tab_k == tdbe_pkg::IDX_W'(tdbe_pkg::SINE_TABLE_DEPTH))
			tab_mag = 17'sd32768;
		else
			tab_mag = $signed({1'b0, tdbe_pkg::SINE_TABLE[tab_k[tdbe_pkg::ADDR_W-1:0]]});
		tab_val = quad_q[1] ? -tab_mag : tab_mag;
	end

	// shared MAC
	logic signed [16:0] mac_a;
	logic signed [24:0] mac_b;
	logic mac_en, mac_clr, mac_sub, mac_hi;
	logic signed [41:0] mac_prod;
	logic signed [65:0] mac_term;

	always_comb begin
		mac_prod = mac_a * mac_b;
		mac_term = mac_hi ? $signed({mac_prod, 24'd0}) : 66'(mac_prod);
		acc_d = (mac_clr ? 66'sd0 : acc_q) + (mac_sub ? -mac_term : mac_term);
	end

	// next state
	logic post_sat;
	always_comb begin
		state_d = state_q;
		case (state_q)
			tdbe_pkg::S_IDLE:  if (s_tvalid) state_d = tdbe_pkg::S_ANG;
			tdbe_pkg::S_ANG:   if (cnt_q == 5'd2)
				state_d = mode_q ? tdbe_pkg::S_BODY : tdbe_pkg::S_EARTH;
			tdbe_pkg::S_EARTH: if (cnt_q == 5'd3) state_d = tdbe_pkg::S_LEAK;
			tdbe_pkg::S_LEAK:  if (cnt_q == 5'd1) state_d = tdbe_pkg::S_DIFF;
			tdbe_pkg::S_DIFF:  state_d = tdbe_pkg::S_DELTA;
			tdbe_pkg::S_DELTA: if (cnt_q == 5'd1) state_d = tdbe_pkg::S_UPD;
			tdbe_pkg::S_UPD:   state_d = j_q ? tdbe_pkg::S_BODY : tdbe_pkg::S_LEAK;
			tdbe_pkg::S_BODY:  if (cnt_q == 5'd7) state_d = tdbe_pkg::S_POST;
			tdbe_pkg::S_POST:  if (post_sat)
				state_d = j_q ? tdbe_pkg::S_DONE : tdbe_pkg::S_POST;
			else
				state_d = tdbe_pkg::S_DIV;
			tdbe_pkg::S_DIV:   if (cnt_q == 5'd31)
				state_d = j_q ? tdbe_pkg::S_DONE : tdbe_pkg::S_POST;
			tdbe_pkg::S_DONE:  if (!m_tvalid_q || m_tready) state_d = tdbe_pkg::S_IDLE;
			default:           state_d = tdbe_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		ang_cos = 1'b0;
		mac_en = 1'b0;
		mac_clr = 1'b0;
		mac_sub = 1'b0;
		mac_hi = 1'b0;
		mac_a = cos_q;
		mac_b = 25'(tilt_q[0]);
		case (state_q)
			tdbe_pkg::S_IDLE: s_tready = 1'b1;
			tdbe_pkg::S_ANG: ang_cos = (cnt_q == 5'd1);
			tdbe_pkg::S_EARTH: begin
				mac_en = 1'b1;
				case (cnt_q[1:0])
					2'd0: begin mac_a = cos_q; mac_b = 25'(tilt_q[0]); mac_clr = 1'b1; end
					2'd1: begin mac_a = sin_q; mac_b = 25'(tilt_q[1]); mac_sub = 1'b1; end
					2'd2: begin mac_a = sin_q; mac_b = 25'(tilt_q[0]); mac_clr = 1'b1; end
					default: begin mac_a = cos_q; mac_b = 25'(tilt_q[1]); end
				endcase
			end
			tdbe_pkg::S_LEAK: begin
				mac_en = 1'b1;
				mac_a = $signed({1'b0, drag_q});
				mac_clr = ~cnt_q[0];
				mac_hi = cnt_q[0];
				mac_b = cnt_q[0] ? tdbe_pkg::hi25(integ_q[j_q]) : tdbe_pkg::lo25(integ_q[j_q]);
			end
			tdbe_pkg::S_DELTA: begin
				mac_en = 1'b1;
				mac_a = $signed({1'b0, dt_q});
				mac_clr = ~cnt_q[0];
				mac_hi = cnt_q[0];
				mac_b = cnt_q[0] ? tdbe_pkg::hi25(diff_q) : tdbe_pkg::lo25(diff_q);
			end
			tdbe_pkg::S_BODY: begin
				mac_en = 1'b1;
				mac_hi = cnt_q[0];
				mac_clr = (cnt_q[1:0] == 2'd0);
				case (cnt_q[2:1])
					2'd0: mac_a = cos_q;
					2'd1: mac_a = sin_q;
					2'd2: mac_a = cos_q;
					default: begin mac_a = sin_q; mac_sub = 1'b1; end
				endcase
				if (cnt_q[2] ^ cnt_q[1])
					mac_b = cnt_q[0] ? tdbe_pkg::hi25(integ_q[1]) : tdbe_pkg::lo25(integ_q[1]);
				else
					mac_b = cnt_q[0] ? tdbe_pkg::hi25(integ_q[0]) : tdbe_pkg::lo25(integ_q[0]);
			end
			default: ;
		endcase
	end

	// integrator update arithmetic
	logic signed [65:0] leak_tr, delta;
	logic signed [66:0] diff_raw, sum_raw;
	logic signed [47:0] diff_sat, sum_sat;
	logic signed [65:0] body_sh;

	always_comb begin
		leak_tr = (acc_q + (acc_q[65] ? 66'sd4095 : 66'sd0)) >>> 12;
		diff_raw = 67'($signed({e_q[j_q], 1'b0})) - 67'(leak_tr);
		if (diff_raw > 67'(tdbe_pkg::I48_MAX))
			diff_sat = 48'(tdbe_pkg::I48_MAX);
		else if (diff_raw < 67'(tdbe_pkg::I48_MIN))
			diff_sat = 48'(tdbe_pkg::I48_MIN);
		else
			diff_sat = diff_raw[47:0];

		delta = (acc_q + (acc_q[65] ? 66'sd65535 : 66'sd0)) >>> 16;
		sum_raw = 67'(integ_q[j_q]) + 67'(delta);
		if (sum_raw > 67'(tdbe_pkg::I48_MAX))
			sum_sat = 48'(tdbe_pkg::I48_MAX);
		else if (sum_raw < 67'(tdbe_pkg::I48_MIN))
			sum_sat = 48'(tdbe_pkg::I48_MIN);
		else
			sum_sat = sum_raw[47:0];

		body_sh = (acc_d + (acc_d[65] ? 66'sd32767 : 66'sd0)) >>> 15;
	end

	// per-axis results
	logic signed [50:0] bj, bj_q16;
	logic [50:0] mag;
	logic [18:0] mag_hi;
	logic signed [31:0] bi_sat;
	logic signed [17:0] cmd18;
	logic signed [15:0] cmd_sat;
	logic [15:0] div_tmp;
	logic div_ge;

	always_comb begin
		bj = body_q[j_q];
		bj_q16 = (bj + (bj[50] ? 51'sd65535 : 51'sd0)) >>> 16;
		if (bj_q16 > 51'sd2147483647)
			bi_sat = 32'sh7fffffff;
		else if (bj_q16 < -51'sd2147483648)
			bi_sat = 32'sh80000000;
		else
			bi_sat = bj_q16[31:0];
		mag = bj[50] ? 51'(-bj) : 51'(bj);
		mag_hi = mag[50:32];
		post_sat = (ba_q == 15'd0) || (mag_hi >= 19'(ba_q));
		cmd18 = ((!bj[50] && (bj != 51'sd0)) ? -$signed({3'd0, ba_q}) : $signed({3'd0, ba_q}))
			+ 18'(trim_q[j_q]);
		if (cmd18 > 18'sd32767)
			cmd_sat = 16'sh7fff;
		else if (cmd18 < -18'sd32768)
			cmd_sat = 16'sh8000;
		else
			cmd_sat = cmd18[15:0];
		div_tmp = {rem_q, quo_q[31]};
		div_ge = (div_tmp >= {1'b0, ba_q});
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdbe_pkg::S_IDLE;
			cnt_q <= 5'd0;
			j_q <= 1'b0;
			ba_q <= 15'd1280;
			drag_q <= 16'd4096;
			integ_q[0] <= 48'sd0;
			integ_q[1] <= 48'sd0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= (state_d != state_q) ? 5'd0 : cnt_q + 5'd1;
			if (cfg_we) begin
				case (cfg_index)
					tdbe_pkg::REG_BRAKE_ANGLE: ba_q <= cfg_data[14:0];
					tdbe_pkg::REG_DRAG_COEF:   drag_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				tdbe_pkg::S_ANG: begin
					j_q <= 1'b0;
					if (cnt_q == 5'd2 && mode_q) begin
						integ_q[0] <= 48'sd0;
						integ_q[1] <= 48'sd0;
					end
				end
				tdbe_pkg::S_UPD: begin
					integ_q[j_q] <= sum_sat;
					j_q <= ~j_q;
				end
				tdbe_pkg::S_BODY: j_q <= 1'b0;
				tdbe_pkg::S_POST: if (post_sat) j_q <= 1'b1;
				tdbe_pkg::S_DIV:  if (cnt_q == 5'd31) j_q <= 1'b1;
				default: ;
			endcase
			if (state_q == tdbe_pkg::S_DONE && state_d == tdbe_pkg::S_IDLE)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (mac_en)
			acc_q <= acc_d;
		case (state_q)
			tdbe_pkg::S_IDLE: if (s_tvalid) begin
				mode_q <= s_tuser;
				yaw_q <= s_tdata[47:32];
				trim_q[0] <= s_tdata[63:48];
				trim_q[1] <= s_tdata[79:64];
				tilt_q[0] <= 17'($signed(s_tdata[15:0])) - 17'($signed(s_tdata[63:48]));
				tilt_q[1] <= 17'($signed(s_tdata[31:16])) - 17'($signed(s_tdata[79:64]));
				dt_q <= s_tdata[95:80];
			end
			tdbe_pkg::S_ANG: begin
				idx_q <= ang_idx;
				quad_q <= ang_quad;
				if (cnt_q == 5'd1)
					sin_q <= tab_val;
				if (cnt_q == 5'd2)
					cos_q <= tab_val;
			end
			tdbe_pkg::S_EARTH: begin
				if (cnt_q == 5'd1)
					e_q[0] <= acc_d[34:0];
				if (cnt_q == 5'd3)
					e_q[1] <= acc_d[34:0];
			end
			tdbe_pkg::S_DIFF: diff_q <= diff_sat;
			tdbe_pkg::S_BODY: begin
				if (cnt_q == 5'd3)
					body_q[0] <= body_sh[50:0];
				if (cnt_q == 5'd7)
					body_q[1] <= body_sh[50:0];
			end
			tdbe_pkg::S_POST: begin
				res_bi_q[j_q] <= bi_sat;
				res_cmd_q[j_q] <= cmd_sat;
				res_bt_q[j_q] <= 32'hffffffff;
				rem_q <= mag_hi[14:0];
				quo_q <= mag[31:0];
			end
			tdbe_pkg::S_DIV: begin
				rem_q <= div_ge ? 15'(div_tmp - {1'b0, ba_q}) : div_tmp[14:0];
				quo_q <= {quo_q[30:0], div_ge};
				if (cnt_q == 5'd31)
					res_bt_q[j_q] <= {quo_q[30:0], div_ge};
			end
			tdbe_pkg::S_DONE: if (!m_tvalid_q || m_tready)
				m_tdata_q <= {res_cmd_q[1], res_cmd_q[0], res_bt_q[1], res_bt_q[0],
					res_bi_q[1], res_bi_q[0]};
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule
`default_nettype wire

// ===== hdl/tdbe_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module tdbe_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [159:0] m_tdata
);

	// busy once a word is taken
	`CHK_NEXT(busy_after_accept, s_tvalid && s_tready, !s_tready)
	// no result can appear in the cycle after a word is taken
	`CHK_NEXT(no_instant_result, s_tvalid && s_tready, !$rose(m_tvalid))
	`CHK_NEXT(out_holds, m_tvalid && !m_tready, m_tvalid)
	`CHK_NEXT(out_stable, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

bind tilt_drag_brake_estimator_unit tdbe_checker u_tdbe_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
`default_nettype wire
